// File: rtl/core/chte_pkg.sv
// Package for the chained hash table engine: sizes, operation codes and helpers.
// Used by every module under rtl/core; depends on nothing.
package chte_pkg;

  localparam int unsigned BUCKETS_DEF = 256;
  localparam int unsigned ENTRIES_DEF = 256;

  localparam int unsigned KEY_W = 64;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned MODE_W = 2;

  // Operation codes carried in the mode field.
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SET    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;
  // Unused code: no table access, all-zero result.
  localparam logic [MODE_W-1:0] MODE_NONE   = 2'd3;

endpackage

// File: rtl/core/chained_hash_table_engine.sv
// Top level of the chained hash table engine: handshake, sequencer and memories.
// Depends on chte_pkg.
//
//  channel | dir | tdata (low bit up)                  | notes
//  in_     | in  | mode[1:0] key[65:2] value_in[97:66] | 104-bit tdata, zero filled
//  out_    | out | found[0] value_out[32:1] refused[33] | 40-bit tdata, zero filled
//
// A hit walks its chain up to the matching entry before the result is formed;
// a miss walks the whole chain. The sequencer returns to idle before the next
// request is taken. A set that appends adds a link step; remove of a non-last entry
// adds a walk of the moved entry's chain up to that entry's position.
// Each chain step is one read of the entry memories, whose registered read
// sets the pace. After reset a clearing pass writes every bucket head
// to empty, during which no request is taken. A result waits in
// the output register; the next request is taken while it waits, and its own
// result is held in the sequencer until the register frees.
module chained_hash_table_engine
  import chte_pkg::*;
#(
  parameter int unsigned BUCKETS = BUCKETS_DEF,
  parameter int unsigned ENTRIES = ENTRIES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [103:0] in_tdata,  // mode, key, value_in
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [39:0]  out_tdata  // found, value_out, refused
);

  localparam int unsigned BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned EW = $clog2(ENTRIES + 1);  // slot index plus NIL
  localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [EW-1:0] NIL = EW'(ENTRIES);
  localparam logic [EW-1:0] EMAX = EW'(ENTRIES);

  // Sequencer states.
  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_HEAD  = 4'd2;  // head read in flight
  localparam logic [3:0] S_WALK  = 4'd3;  // decide on current slot
  localparam logic [3:0] S_ENT   = 4'd4;  // entry read in flight
  localparam logic [3:0] S_ACT   = 4'd5;  // act on search result
  localparam logic [3:0] S_LAST  = 4'd6;  // last entry read in flight (remove) or link step (set)
  localparam logic [3:0] S_MHEAD = 4'd7;  // second search head read
  localparam logic [3:0] S_MWALK = 4'd8;
  localparam logic [3:0] S_MENT  = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  // Memories.
  logic [EW-1:0]    head_mem [BUCKETS];
  logic [KEY_W-1:0] key_mem  [ENTRIES];
  logic [EW-1:0]    link_mem [ENTRIES];
  logic [VAL_W-1:0] val_mem  [ENTRIES];

  logic [EW-1:0]    head_q;
  logic [KEY_W-1:0] key_q;
  logic [EW-1:0]    link_q;
  logic [VAL_W-1:0] val_q;

  logic [3:0]        state_r;
  logic [BW-1:0]     clr_r;
  logic [MODE_W-1:0] mode_r;
  logic [KEY_W-1:0]  key_r;
  logic [VAL_W-1:0]  vin_r;
  logic [BW-1:0]     bkt_r;
  logic [EW-1:0]     cur_r, pred_r, slot_r, cnt_r, steps_r;
  logic [EW-1:0]     slink_r;      // link of the hit entry
  logic [KEY_W-1:0]  lkey_r;       // key of moved (last) entry
  logic [BW-1:0]     mbkt_r;
  logic              res_valid_r;
  logic [39:0]       res_r;        // result under construction
  logic [39:0]       out_r;        // result waiting on the output

  // Memory port controls.
  logic          hw_en, ew_key, ew_val, ew_link;
  logic [BW-1:0] h_addr_w, h_addr_r;
  logic [EW-1:0] h_wdata;
  logic [AW-1:0] e_addr_w, e_addr_r, l_addr_w;
  logic [KEY_W-1:0] e_kdata;
  logic [VAL_W-1:0] e_vdata;
  logic [EW-1:0]    l_wdata;

  always_ff @(posedge clk) begin
    if (hw_en) head_mem[h_addr_w] <= h_wdata;
    head_q <= head_mem[h_addr_r];
  end

  always_ff @(posedge clk) begin
    if (ew_key) key_mem[e_addr_w] <= e_kdata;
    if (ew_val) val_mem[e_addr_w] <= e_vdata;
    if (ew_link) link_mem[l_addr_w] <= l_wdata;
    key_q  <= key_mem[e_addr_r];
    val_q  <= val_mem[e_addr_r];
    link_q <= link_mem[e_addr_r];
  end

  logic in_acc;
  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = res_valid_r;
  assign out_tdata  = out_r;

  logic [3:0]     state_nxt;
  logic [BW-1:0]  clr_nxt;
  logic [EW-1:0]  cur_nxt, pred_nxt, slot_nxt, cnt_nxt, steps_nxt;
  logic           res_valid_nxt;
  logic [39:0]    res_nxt;
  logic [39:0]    out_nxt;
  logic [KEY_W-1:0] in_key;
  logic           walk_live;

  assign in_key = in_tdata[65:2];
  assign walk_live  = (cur_r < cnt_r) && (steps_r < EMAX);

  // Sequencer next state and memory port controls; link writes go to the predecessor entry or bucket head.
  always_comb begin
    state_nxt = state_r;
    clr_nxt = clr_r;
    cur_nxt = cur_r;
    pred_nxt = pred_r;
    slot_nxt = slot_r;
    cnt_nxt = cnt_r;
    steps_nxt = steps_r;
    res_valid_nxt = res_valid_r && !out_tready;
    res_nxt = res_r;
    out_nxt = out_r;
    hw_en = 1'b0; ew_key = 1'b0; ew_val = 1'b0; ew_link = 1'b0;
    h_addr_w = clr_r; h_addr_r = bkt_r; h_wdata = NIL;
    e_addr_w = cur_r[AW-1:0]; e_addr_r = cur_r[AW-1:0]; l_addr_w = cur_r[AW-1:0];
    e_kdata = key_r; e_vdata = vin_r; l_wdata = NIL;
    unique case (state_r)
      S_CLR: begin
        hw_en = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == BW'(BUCKETS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        h_addr_r = BW'(in_key % BUCKETS);
        if (in_acc) begin
          pred_nxt = NIL;
          steps_nxt = '0;
          slot_nxt = NIL;
          state_nxt = (in_tdata[1:0] == MODE_NONE) ? S_DONE : S_HEAD;
        end
      end
      S_HEAD: begin
        cur_nxt = head_q;
        state_nxt = S_WALK;
      end
      S_WALK: begin
        if (walk_live) state_nxt = S_ENT;
        else state_nxt = S_ACT;
      end
      S_ENT: begin
        if (key_q == key_r) begin
          slot_nxt = cur_r;
          state_nxt = S_ACT;
        end else begin
          pred_nxt = cur_r;
          cur_nxt = link_q;
          steps_nxt = steps_r + 1'b1;
          state_nxt = S_WALK;
        end
      end
      S_ACT: begin
        state_nxt = S_DONE;
        res_nxt = '0;
        res_nxt[0] = (slot_r != NIL);
        unique case (mode_r)
          MODE_LOOKUP: if (slot_r != NIL) res_nxt[32:1] = val_q;
          MODE_SET: begin
            if (slot_r != NIL) begin
              ew_val = 1'b1; e_addr_w = slot_r[AW-1:0];
            end else if (cnt_r >= EMAX) begin
              res_nxt[33] = 1'b1;
            end else begin
              ew_key = 1'b1; ew_val = 1'b1; ew_link = 1'b1;
              e_addr_w = cnt_r[AW-1:0]; l_addr_w = cnt_r[AW-1:0]; l_wdata = NIL;
              cnt_nxt = cnt_r + 1'b1;
              state_nxt = S_LAST;  // link step follows
              cur_nxt = cnt_r;
            end
          end
          MODE_REMOVE: begin
            if (slot_r != NIL) begin
              // Unlink, then fetch last entry.
              if (pred_r != NIL) begin
                ew_link = 1'b1; l_addr_w = pred_r[AW-1:0]; l_wdata = link_q;
              end else begin
                hw_en = 1'b1; h_addr_w = bkt_r; h_wdata = link_q;
              end
              e_addr_r = AW'(cnt_r - 1'b1);
              cnt_nxt = cnt_r - 1'b1;
              state_nxt = (slot_r == cnt_r - 1'b1) ? S_DONE : S_LAST;
            end
          end
          default: ;
        endcase
      end
      S_LAST: begin
        if (mode_r == MODE_SET) begin
          // Link the new entry at the end of its chain.
          if (pred_r != NIL) begin
            ew_link = 1'b1; l_addr_w = pred_r[AW-1:0]; l_wdata = cur_r;
          end else begin
            hw_en = 1'b1; h_addr_w = bkt_r; h_wdata = cur_r;
          end
          state_nxt = S_DONE;
        end else begin
          // Copy last entry into the freed slot, then search its chain. When the
          // last entry preceded the freed slot, its link was rewritten by the unlink.
          ew_key = 1'b1; ew_val = 1'b1; ew_link = 1'b1;
          e_addr_w = slot_r[AW-1:0]; l_addr_w = slot_r[AW-1:0];
          e_kdata = key_q; e_vdata = val_q;
          l_wdata = (pred_r == cnt_r) ? slink_r : link_q;
          h_addr_r = BW'(key_q % BUCKETS);
          pred_nxt = NIL;
          steps_nxt = '0;
          state_nxt = S_MHEAD;
        end
      end
      S_MHEAD: begin
        cur_nxt = head_q;
        state_nxt = S_MWALK;
      end
      S_MWALK: begin
        // Walk with the old count (last slot still counted live).
        if ((cur_r < cnt_r + 1'b1) && (steps_r < EMAX)) state_nxt = S_MENT;
        else state_nxt = S_DONE;
      end
      S_MENT: begin
        // The freed slot already holds the copy, so it stands for the removed
        // entry here and is followed through its old link.
        if (cur_r != slot_r && key_q == lkey_r) begin
          if (pred_r != NIL) begin
            ew_link = 1'b1; l_addr_w = pred_r[AW-1:0]; l_wdata = slot_r;
          end else begin
            hw_en = 1'b1; h_addr_w = mbkt_r; h_wdata = slot_r;
          end
          state_nxt = S_DONE;
        end else begin
          pred_nxt = cur_r;
          cur_nxt = (cur_r == slot_r) ? slink_r : link_q;
          steps_nxt = steps_r + 1'b1;
          state_nxt = S_MWALK;
        end
      end
      S_DONE: begin
        if (!res_valid_r || out_tready) begin
          res_valid_nxt = 1'b1;
          if (mode_r == MODE_NONE) out_nxt = '0;
          else out_nxt = res_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    // Entry reads follow the walk pointer.
    if (state_nxt == S_ENT || state_nxt == S_MENT) e_addr_r = cur_nxt[AW-1:0];
    if (state_nxt == S_ACT && state_r == S_ENT) e_addr_r = cur_r[AW-1:0];
    if (state_nxt == S_ACT && state_r == S_WALK) e_addr_r = cur_r[AW-1:0];
  end

  // Note: S_ACT is reached from S_ENT on a hit, where entry data of the hit
  // slot is still on the read port (read address held on cur_r).

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r <= '0;
      cnt_r <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      cnt_r <= cnt_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    pred_r <= pred_nxt;
    slot_r <= slot_nxt;
    steps_r <= steps_nxt;
    res_r <= res_nxt;
    out_r <= out_nxt;
    if (in_acc) begin
      mode_r <= in_tdata[1:0];
      key_r  <= in_key;
      vin_r  <= in_tdata[97:66];
      bkt_r  <= BW'(in_key % BUCKETS);
    end
    if (state_r == S_ACT) slink_r <= link_q;
    if (state_r == S_LAST) begin
      lkey_r  <= key_q;
      mbkt_r  <= BW'(key_q % BUCKETS);
    end
  end

endmodule
